### hdl/segment_reassembly_receiver_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment reassembly receiver
// Clocked property checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_REASSEMBLY_RECEIVER_UNIT_MACROS_SVH
`define SEGMENT_REASSEMBLY_RECEIVER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define SRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define SRR_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define SRR_ASSERT(lbl, prop, msg)
`define SRR_NEVER(lbl, expr, msg)
`endif

`endif

### hdl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Types and constants shared by the segment reassembly receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int BUFFER_BYTES_DEF = 2048;
    localparam int HDR_LEN          = 6;
    localparam int SENSE_LEN        = 2;
    localparam logic [7:0] SEG_BYTES_RST = 8'd128;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_LW    = 3;

    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_ACK   = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_SENSE = 3'd3,
        KIND_CTRL  = 3'd4,
        KIND_DROP  = 3'd5
    } t_kind;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [10:0] read_addr;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seg_index;
        logic [7:0]  seg_total;
        logic [31:0] block_base;
        logic [11:0] total_length;
        logic [7:0]  read_data;
        logic        last;
    } t_out_item;

    // results of one frame byte: count and up to two items
    typedef struct packed {
        logic [1:0] n;
        t_out_item  r0;
        t_out_item  r1;
    } t_res_bundle;

endpackage

### hdl/segment_reassembly_receiver_unit.sv
// ----------------------------------------------------------------------------
// segment_reassembly_receiver_unit
// Frame byte receiver that reassembles segmented blocks into a byte buffer.
// ----------------------------------------------------------------------------
// Takes one item per clock while o_in_stall is low: either a received frame byte
// (mode 0) or a buffer read (mode 1). Each frame byte is at most a single write into
// the reassembly memory, done in the cycle it is accepted; a read issues on
// the memory's read port in its accept cycle and the byte returns in the cycle
// after. Results (read data, ack, block complete, sensing, control, dropped)
// are pushed into a four-entry queue at the clock edge after the one that
// accepted the item. The input stalls only when that queue and the stage
// in front of it cannot take two more results, so a stalled output
// eventually stalls the input. The buffer is not cleared after reset:
// reading a byte that was never written returns whatever the memory holds.
// segment_bytes may be written whenever no result is pending; the new value
// applies from the next frame byte. The config port is always ready.
// ----------------------------------------------------------------------------
`include "segment_reassembly_receiver_unit_macros.svh"

module segment_reassembly_receiver_unit import srr_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config: segment_bytes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    // result items
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]      r_seg_bytes;

    // stage 1: results of the item accepted last cycle
    logic [1:0]      r_s1_n;
    logic            r_s1_read;
    logic            r_s1_oob;
    t_res_bundle     r_s1_res;

    logic            accept;
    t_res_bundle     frame_res;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;
    logic            re;
    logic [31:0]     ra_ext;
    logic [AW-1:0]   raddr;
    logic            rd_oob;
    logic [7:0]      rdata;
    t_out_item       item0;
    logic [Q_LW-1:0] q_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_bytes <= SEG_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seg_bytes <= i_cfg_data;
        end
    end

    // Room check: whatever sits in stage 1 plus up to two new results must fit
    // the queue. Depends only on registered state, never on i_out_stall.
    assign o_in_stall = ({1'b0, q_level} + {2'b00, r_s1_n}) > 4'(Q_DEPTH - 2);
    assign accept     = i_in_valid && !o_in_stall;

    // read path: addresses beyond the buffer read as zero
    assign re     = accept && i_in_item.mode;
    assign ra_ext = 32'(i_in_item.read_addr);
    assign raddr  = ra_ext[AW-1:0];
    assign rd_oob = ra_ext >= 32'(BUFFER_BYTES);

    srr_frame_ctl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_frame_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_seg_bytes (r_seg_bytes),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_res       (frame_res)
    );

    srr_buffer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_n    <= '0;
            r_s1_read <= 1'b0;
        end else if (accept) begin
            r_s1_n    <= i_in_item.mode ? 2'd1 : frame_res.n;
            r_s1_read <= i_in_item.mode;
        end else begin
            r_s1_n    <= '0;
            r_s1_read <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= frame_res;
            r_s1_oob <= rd_oob;
        end
    end

    // memory data joins the read result here
    always_comb begin
        item0 = r_s1_res.r0;
        if (r_s1_read) begin
            item0           = '0;
            item0.kind      = KIND_READ;
            item0.read_data = r_s1_oob ? 8'd0 : rdata;
            item0.last      = 1'b1;
        end
    end

    srr_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (r_s1_n),
        .i_item0  (item0),
        .i_item1  (r_s1_res.r1),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item),
        .o_level  (q_level)
    );

    `SRR_ASSERT(a_read_single, r_s1_read |-> (r_s1_n == 2'd1), "read gives one result")

endmodule

### hdl/srr_buffer.sv
// ----------------------------------------------------------------------------
// srr_buffer
// Reassembly byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srr_buffer #(
    parameter int BUFFER_BYTES = 2048,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [BUFFER_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/srr_frame_ctl.sv
// ----------------------------------------------------------------------------
// srr_frame_ctl
// Header parse, block bookkeeping, store decisions and frame-end results.
// ----------------------------------------------------------------------------
`include "segment_reassembly_receiver_unit_macros.svh"

module srr_frame_ctl import srr_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES),
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  t_in_item      i_item,
    input  logic [7:0]    i_seg_bytes,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output t_res_bundle   o_res
);

    logic [7:0]              r_pos;
    logic [47:0]             r_hdr;
    logic [31:0]             r_base;
    logic                    r_open;
    logic [7:0]              r_exp;
    logic [MAX_SEGMENTS-1:0] r_map;
    logic [CW-1:0]           r_count;
    logic [11:0]             r_total;
    logic                    r_keep;
    logic [15:0]             r_stored;

    logic                    acc_frame;
    logic [47:0]             n_hdr;
    logic [7:0]              idx;
    logic [7:0]              cnt;
    logic [31:0]             base;
    logic                    at_dec;
    logic                    open_new;
    logic                    open_e;
    logic [7:0]              exp_e;
    logic [MAX_SEGMENTS-1:0] map_e;
    logic [CW-1:0]           count_e;
    logic [11:0]             total_e;
    logic [31:0]             base_e;
    logic                    map_hit;
    logic [MAX_SEGMENTS-1:0] map_sel;
    logic                    keep_e;
    logic [15:0]             stored_e;
    logic [15:0]             seg_base;
    logic [7:0]              off;
    logic [16:0]             waddr_full;
    logic                    we;
    logic [15:0]             n_stored;
    logic [CW-1:0]           n_count;
    logic [16:0]             tsum;
    logic [11:0]             n_total;
    logic                    is_ack;
    logic                    done;

    assign acc_frame = i_accept && !i_item.mode;

    // header shifts in during the first six bytes
    assign n_hdr = (r_pos < 8'(HDR_LEN)) ? {r_hdr[39:0], i_item.data_byte} : r_hdr;
    assign idx   = n_hdr[47:40];
    assign cnt   = n_hdr[39:32];
    assign base  = n_hdr[31:0];

    // first payload byte: decide whether a new block opens
    assign at_dec   = (r_pos == 8'(HDR_LEN));
    assign open_new = at_dec && (idx == 8'd0) && (cnt != 8'd0)
                   && (cnt <= 8'(MAX_SEGMENTS)) && (!r_open || base != r_base);

    assign open_e  = r_open | open_new;
    assign exp_e   = open_new ? cnt : r_exp;
    assign map_e   = open_new ? '0 : r_map;
    assign count_e = open_new ? '0 : r_count;
    assign total_e = open_new ? 12'd0 : r_total;
    assign base_e  = open_new ? base : r_base;

    always_comb begin
        map_hit = 1'b0;
        map_sel = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            if (idx == 8'(i)) begin
                map_hit    = map_e[i];
                map_sel[i] = 1'b1;
            end
        end
    end

    assign keep_e = at_dec ? (open_e && idx < exp_e && idx < 8'(MAX_SEGMENTS) && !map_hit)
                           : r_keep;
    assign stored_e = at_dec ? 16'd0 : r_stored;

    // segment start: header index times the current segment size
    assign seg_base   = 16'(idx) * 16'(i_seg_bytes);
    assign off        = r_pos - 8'(HDR_LEN);
    assign waddr_full = 17'(seg_base) + 17'(off);
    assign we = acc_frame && (r_pos >= 8'(HDR_LEN)) && keep_e
             && (off < i_seg_bytes) && (waddr_full < 17'(BUFFER_BYTES));

    assign o_we    = we;
    assign o_waddr = waddr_full[AW-1:0];
    assign o_wdata = i_item.data_byte;

    assign n_stored = stored_e + 16'(we);
    assign n_count  = count_e + CW'(1);
    assign tsum     = 17'(total_e) + 17'(n_stored);
    assign n_total  = (tsum > 17'd4095) ? 12'hFFF : tsum[11:0];

    assign is_ack = (r_pos >= 8'(HDR_LEN)) && keep_e;
    assign done   = is_ack && (8'(n_count) == exp_e);

    always_comb begin
        o_res         = '0;
        o_res.r0.kind = KIND_DROP;
        o_res.r0.last = 1'b1;
        o_res.r1.kind = KIND_DONE;
        o_res.r1.last = 1'b1;
        if (acc_frame && i_item.frame_end) begin
            o_res.n = 2'd1;
            if (r_pos == 8'(SENSE_LEN - 1)) begin
                o_res.r0.kind = KIND_SENSE;
            end else if (r_pos == 8'(HDR_LEN - 1)) begin
                o_res.r0.kind = KIND_CTRL;
            end else if (is_ack) begin
                o_res.r0.kind       = KIND_ACK;
                o_res.r0.seg_index  = idx;
                o_res.r0.seg_total  = cnt;
                o_res.r0.block_base = base;
                if (done) begin
                    o_res.n               = 2'd2;
                    o_res.r0.last         = 1'b0;
                    o_res.r1.seg_total    = exp_e;
                    o_res.r1.block_base   = base_e;
                    o_res.r1.total_length = n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr    <= '0;
            r_base   <= '0;
            r_open   <= 1'b0;
            r_exp    <= '0;
            r_map    <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_keep   <= 1'b0;
            r_stored <= '0;
        end else if (acc_frame) begin
            if (open_new) begin
                r_base <= base;
                r_open <= 1'b1;
                r_exp  <= cnt;
            end
            if (i_item.frame_end && is_ack) begin
                r_map   <= map_e | map_sel;
                r_count <= n_count;
                r_total <= n_total;
            end else begin
                r_map   <= map_e;
                r_count <= count_e;
                r_total <= total_e;
            end
            if (i_item.frame_end) begin
                r_pos    <= '0;
                r_hdr    <= '0;
                r_keep   <= 1'b0;
                r_stored <= '0;
            end else begin
                r_pos    <= (r_pos == 8'hFF) ? r_pos : r_pos + 8'd1;
                r_hdr    <= n_hdr;
                r_keep   <= keep_e;
                r_stored <= n_stored;
            end
        end
    end

    `SRR_ASSERT(a_keep_needs_block, r_keep |-> r_open, "frame kept with no block open")
    `SRR_ASSERT(a_map_matches_count, $countones(r_map) == int'(r_count), "map/count mismatch")
    `SRR_ASSERT(a_count_in_range, r_open |-> (8'(r_count) <= r_exp), "received count above expected")

endmodule

### hdl/srr_out_queue.sv
// ----------------------------------------------------------------------------
// srr_out_queue
// Small result queue, up to two items in per cycle, one out unless i_stall is high.
// ----------------------------------------------------------------------------
`include "segment_reassembly_receiver_unit_macros.svh"

module srr_out_queue import srr_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_n,
    input  t_out_item       i_item0,
    input  t_out_item       i_item1,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_item       o_item,
    output logic [Q_LW-1:0] o_level
);

    t_out_item       r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_LW-1:0] r_cnt;
    logic            pop;
    logic [Q_AW-1:0] wp1;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_slot[r_rp];
    assign o_level = r_cnt;
    assign pop     = o_valid && !i_stall;
    assign wp1     = r_wp + Q_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_slot[r_wp] <= i_item0;
        end
        if (i_push_n == 2'd2) begin
            r_slot[wp1] <= i_item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push_n);
            r_rp  <= r_rp + Q_AW'(pop);
            r_cnt <= r_cnt + Q_LW'(i_push_n) - Q_LW'(pop);
        end
    end

    `SRR_NEVER(a_q_overflow, (int'(r_cnt) + int'(i_push_n)) > Q_DEPTH, "result queue overflow")

endmodule
